>>> hdl/ppds_pkg.sv
// Shared types, constants and helper functions of the density scale core.
`default_nettype none

package ppds_pkg;

    localparam int MAX_BREAKPOINTS = 4;
    localparam int RADIUS_W        = 16;
    localparam int SCALE_W         = 16;
    localparam int EXP_W           = 16;
    localparam int SEG_W           = 2;
    localparam int WORD_W          = 48;
    localparam int USED_W          = 3;
    localparam int CFG_IDX_W       = 3;

    // divider: quotient bits per stage and stage count
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = RADIUS_W / DIV_STEP;

    // log / exp datapath
    localparam int FRAC_W  = 16;   // fraction bits of the log value
    localparam int MANT_W  = 31;   // Q1.30 mantissa
    localparam int COEF_W  = 30;   // Q1.30 factor, always below 1.0
    localparam int LZ_W    = 5;    // integer part of -log2, 0..16
    localparam int NL_W    = 21;   // -log2 in Q.16
    localparam int E_W     = 25;   // scaled log in Q.16
    localparam int SHIFT_W = 5;
    localparam int Q_W     = 18;   // rounded scale change
    localparam int RES_W   = 19;   // signed result before clamp

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_USED  = 3'd0;
    localparam t_cfg_idx REG_WORD0 = 3'd1;
    localparam t_cfg_idx REG_WORD1 = 3'd2;
    localparam t_cfg_idx REG_WORD2 = 3'd3;
    localparam t_cfg_idx REG_WORD3 = 3'd4;

    typedef logic [WORD_W-1:0] t_word;

    localparam logic [USED_W-1:0] USED_RESET  = 3'd1;
    localparam t_word             WORD0_RESET = 48'h0000_1000_0000;
    localparam t_word             WORD_RESET  = '0;

    localparam logic [SCALE_W-1:0] ONE_Q12    = 16'h1000;
    localparam logic [MANT_W-1:0]  ONE_Q30    = 31'h4000_0000;
    localparam logic [SCALE_W-1:0] SCALE_MAX  = 16'hFFFF;
    localparam logic [8:0]         SHIFT_KILL = 9'd31;

    // sideband that travels with each request down the pipe
    typedef struct packed {
        logic               bypass;   // result is sc0 as is
        logic [SCALE_W-1:0] sc0;
        logic [SCALE_W-1:0] sc1;
        logic [EXP_W-1:0]   pex;      // signed Q4.12 exponent
        logic [SEG_W-1:0]   seg;
    } t_side;

    // log stage -> exp stage command
    typedef struct packed {
        logic               kill;     // power is zero
        logic [SHIFT_W-1:0] shift;
        logic [FRAC_W-1:0]  frac;
    } t_pow_cmd;

    function automatic logic [RADIUS_W-1:0] bp_radius(input t_word w);
        return w[47:32];
    endfunction

    function automatic logic [SCALE_W-1:0] bp_scale(input t_word w);
        return w[31:16];
    endfunction

    function automatic logic [EXP_W-1:0] bp_exp(input t_word w);
        return w[15:0];
    endfunction

    // floor square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] probe;
        x     = v;
        res   = '0;
        probe = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (probe > x) probe = probe >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (probe != 64'd0) begin
                if (x >= res + probe) begin
                    x   = x - (res + probe);
                    res = (res >> 1) + probe;
                end else begin
                    res = res >> 1;
                end
                probe = probe >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-2^-idx) in Q1.30, chained square roots from 0.5
    function automatic logic [COEF_W-1:0] root_coef(input int idx);
        logic [63:0] c;
        c = 64'h2000_0000;
        for (int i = 1; i <= FRAC_W; i++) begin
            if (i <= idx) c = isqrt64(c << 30);
        end
        return c[COEF_W-1:0];
    endfunction

    localparam logic [COEF_W-1:0] ROOT_COEF [FRAC_W] = '{
        root_coef(1),  root_coef(2),  root_coef(3),  root_coef(4),
        root_coef(5),  root_coef(6),  root_coef(7),  root_coef(8),
        root_coef(9),  root_coef(10), root_coef(11), root_coef(12),
        root_coef(13), root_coef(14), root_coef(15), root_coef(16)
    };

endpackage

`default_nettype wire

>>> hdl/ppds_if.sv
// Request and result channel interfaces of the density scale core.
`default_nettype none

interface ppds_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] radius;

    modport source (output valid, output radius, input ready);
    modport sink   (input valid, input radius, output ready);
endinterface

interface ppds_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] density_scale;
    logic [1:0]  segment_used;

    modport source (output valid, output density_scale, output segment_used, input ready);
    modport sink   (input valid, input density_scale, input segment_used, output ready);
endinterface

`default_nettype wire

>>> hdl/ppds_seg.sv
// Segment search over the breakpoint table and setup of offset and width.
`default_nettype none

module ppds_seg (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic [ppds_pkg::RADIUS_W-1:0]           i_radius,
    input  logic [ppds_pkg::USED_W-1:0]             i_used,
    input  ppds_pkg::t_word                         i_words [ppds_pkg::MAX_BREAKPOINTS],
    output logic                                    o_valid,
    output ppds_pkg::t_side                         o_side,
    output logic [ppds_pkg::RADIUS_W-1:0]           o_off,
    output logic [ppds_pkg::RADIUS_W-1:0]           o_width
);
    import ppds_pkg::*;

    logic                r_valid;
    t_side               r_side;
    logic [RADIUS_W-1:0] r_off;
    logic [RADIUS_W-1:0] r_width;

    t_side               n_side;
    logic [RADIUS_W-1:0] n_off;
    logic [RADIUS_W-1:0] n_width;

    always_comb begin
        logic [SEG_W-1:0]  nm1;
        logic [SEG_W-1:0]  s;
        logic [SEG_W-1:0]  j;
        logic [USED_W-1:0] dec;
        logic              found;
        dec = i_used - USED_W'(1);
        priority if (i_used == '0) begin
            nm1 = '0;
        end else if (i_used > USED_W'(MAX_BREAKPOINTS)) begin
            nm1 = SEG_W'(MAX_BREAKPOINTS - 1);
        end else begin
            nm1 = dec[SEG_W-1:0];
        end

        s     = nm1;
        found = 1'b0;
        for (int i = 0; i < MAX_BREAKPOINTS - 1; i++) begin
            if (!found && SEG_W'(i) < nm1 && i_radius < bp_radius(i_words[i])) begin
                s     = SEG_W'(i);
                found = 1'b1;
            end
        end
        j = s - SEG_W'(1);

        n_side.sc1 = bp_scale(i_words[s]);
        n_side.pex = bp_exp(i_words[j]);
        n_off      = i_radius - bp_radius(i_words[j]);
        n_width    = bp_radius(i_words[s]) - bp_radius(i_words[j]);

        priority if (s == nm1 && i_radius >= bp_radius(i_words[s])) begin
            // at or past the last breakpoint
            n_side.bypass = 1'b1;
            n_side.sc0    = bp_scale(i_words[s]);
            n_side.seg    = s;
        end else if (s == '0) begin
            // below the first breakpoint
            n_side.bypass = 1'b1;
            n_side.sc0    = bp_scale(i_words[0]);
            n_side.seg    = '0;
        end else begin
            n_side.bypass = 1'b0;
            n_side.sc0    = bp_scale(i_words[j]);
            n_side.seg    = j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side  <= n_side;
            r_off   <= n_off;
            r_width <= n_width;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_off   = r_off;
    assign o_width = r_width;

endmodule

`default_nettype wire

>>> hdl/ppds_div.sv
// Pipelined restoring divider: t = floor(off * 2^16 / width).
`default_nettype none

module ppds_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ppds_pkg::t_side               i_side,
    input  logic [ppds_pkg::RADIUS_W-1:0] i_off,
    input  logic [ppds_pkg::RADIUS_W-1:0] i_width,
    output logic                          o_valid,
    output ppds_pkg::t_side               o_side,
    output logic [ppds_pkg::RADIUS_W-1:0] o_quot
);
    import ppds_pkg::*;

    logic                r_valid [DIV_STAGES];
    t_side               r_side  [DIV_STAGES];
    logic [RADIUS_W-1:0] r_rem   [DIV_STAGES];
    logic [RADIUS_W-1:0] r_quot  [DIV_STAGES];
    logic [RADIUS_W-1:0] r_width [DIV_STAGES];

    logic [RADIUS_W-1:0] n_rem   [DIV_STAGES];
    logic [RADIUS_W-1:0] n_quot  [DIV_STAGES];

    always_comb begin
        logic [RADIUS_W:0]   dbl;
        logic [RADIUS_W-1:0] rem;
        logic [RADIUS_W-1:0] quot;
        logic [RADIUS_W-1:0] wdt;
        for (int g = 0; g < DIV_STAGES; g++) begin
            if (g == 0) begin
                rem  = i_off;
                quot = '0;
                wdt  = i_width;
            end else begin
                rem  = r_rem[g-1];
                quot = r_quot[g-1];
                wdt  = r_width[g-1];
            end
            for (int k = 0; k < DIV_STEP; k++) begin
                dbl = {rem, 1'b0};
                if (dbl >= {1'b0, wdt}) begin
                    dbl  = dbl - {1'b0, wdt};
                    quot = {quot[RADIUS_W-2:0], 1'b1};
                end else begin
                    quot = {quot[RADIUS_W-2:0], 1'b0};
                end
                rem = dbl[RADIUS_W-1:0];
            end
            n_rem[g]  = rem;
            n_quot[g] = quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < DIV_STAGES; g++) r_valid[g] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int g = 1; g < DIV_STAGES; g++) r_valid[g] <= r_valid[g-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0]  <= i_side;
            r_width[0] <= i_width;
            for (int g = 1; g < DIV_STAGES; g++) begin
                r_side[g]  <= r_side[g-1];
                r_width[g] <= r_width[g-1];
            end
            for (int g = 0; g < DIV_STAGES; g++) begin
                r_rem[g]  <= n_rem[g];
                r_quot[g] <= n_quot[g];
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];
    assign o_quot  = r_quot[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> hdl/ppds_log.sv
// Base selection, -log2 by repeated squaring, and scaling by the exponent.
`default_nettype none

module ppds_log (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ppds_pkg::t_side               i_side,
    input  logic [ppds_pkg::RADIUS_W-1:0] i_t,
    output logic                          o_valid,
    output ppds_pkg::t_side               o_side,
    output ppds_pkg::t_pow_cmd            o_cmd
);
    import ppds_pkg::*;

    // prep stage
    logic                r_p_valid;
    t_side               r_p_side;
    logic [MANT_W-1:0]   r_p_mant;
    logic [LZ_W-1:0]     r_p_lz;
    logic [EXP_W-1:0]    r_p_pexp;
    logic                r_p_zero;

    // squaring stages
    logic                r_s_valid [FRAC_W];
    t_side               r_s_side  [FRAC_W];
    logic [MANT_W-1:0]   r_s_mant  [FRAC_W];
    logic [FRAC_W-1:0]   r_s_frac  [FRAC_W];
    logic [LZ_W-1:0]     r_s_lz    [FRAC_W];
    logic [EXP_W-1:0]    r_s_pexp  [FRAC_W];
    logic                r_s_zero  [FRAC_W];

    // exponent scaling stage
    logic                r_e_valid;
    t_side               r_e_side;
    t_pow_cmd            r_e_cmd;

    logic [MANT_W-1:0]   n_p_mant;
    logic [LZ_W-1:0]     n_p_lz;
    logic [EXP_W-1:0]    n_p_pexp;
    logic                n_p_zero;
    logic [MANT_W-1:0]   n_s_mant [FRAC_W];
    logic [FRAC_W-1:0]   n_s_frac [FRAC_W];
    t_pow_cmd            n_e_cmd;

    always_comb begin
        logic [RADIUS_W:0] base;
        logic [LZ_W-1:0]   lead;
        logic              neg;
        neg = i_side.pex[EXP_W-1];
        // negative exponent works on 1 - t, so 1.0 stays exact
        base = neg ? ((RADIUS_W+1)'(1) << RADIUS_W) - {1'b0, i_t} : {1'b0, i_t};
        lead = '0;
        for (int i = 0; i <= RADIUS_W; i++) begin
            if (base[i]) lead = LZ_W'(i);
        end
        n_p_zero = (base == '0);
        n_p_mant = MANT_W'({{(MANT_W-RADIUS_W-1){1'b0}}, base} << (LZ_W'(MANT_W-1) - lead));
        n_p_lz   = LZ_W'(RADIUS_W) - lead;
        n_p_pexp = neg ? EXP_W'(-i_side.pex) : i_side.pex;
    end

    always_comb begin
        logic [2*MANT_W-1:0] prod;
        logic [MANT_W:0]     sq;
        logic [MANT_W-1:0]   mant;
        logic [FRAC_W-1:0]   frac;
        for (int g = 0; g < FRAC_W; g++) begin
            if (g == 0) begin
                mant = r_p_mant;
                frac = '0;
            end else begin
                mant = r_s_mant[g-1];
                frac = r_s_frac[g-1];
            end
            prod = {{MANT_W{1'b0}}, mant} * {{MANT_W{1'b0}}, mant};
            sq   = prod[2*MANT_W-1:MANT_W-1];
            if (sq[MANT_W]) begin
                n_s_mant[g] = sq[MANT_W:1];
                n_s_frac[g] = {frac[FRAC_W-2:0], 1'b1};
            end else begin
                n_s_mant[g] = sq[MANT_W-1:0];
                n_s_frac[g] = {frac[FRAC_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [NL_W-1:0]      nl;
        logic [NL_W+EXP_W-1:0] prod;
        logic [NL_W+EXP_W-1:0] sum;
        logic [E_W-1:0]       e;
        nl   = {r_s_lz[FRAC_W-1], {FRAC_W{1'b0}}} - {{LZ_W{1'b0}}, r_s_frac[FRAC_W-1]};
        prod = {{EXP_W{1'b0}}, nl} * {{NL_W{1'b0}}, r_s_pexp[FRAC_W-1]};
        sum  = prod + (NL_W+EXP_W)'(2048);
        e    = sum[NL_W+EXP_W-1:12];
        n_e_cmd.kill  = r_s_zero[FRAC_W-1] || (e[E_W-1:FRAC_W] >= SHIFT_KILL);
        n_e_cmd.shift = e[FRAC_W+SHIFT_W-1:FRAC_W];
        n_e_cmd.frac  = e[FRAC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            for (int g = 0; g < FRAC_W; g++) r_s_valid[g] <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid    <= i_valid;
            r_s_valid[0] <= r_p_valid;
            for (int g = 1; g < FRAC_W; g++) r_s_valid[g] <= r_s_valid[g-1];
            r_e_valid    <= r_s_valid[FRAC_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_side <= i_side;
            r_p_mant <= n_p_mant;
            r_p_lz   <= n_p_lz;
            r_p_pexp <= n_p_pexp;
            r_p_zero <= n_p_zero;

            r_s_side[0] <= r_p_side;
            r_s_lz[0]   <= r_p_lz;
            r_s_pexp[0] <= r_p_pexp;
            r_s_zero[0] <= r_p_zero;
            for (int g = 1; g < FRAC_W; g++) begin
                r_s_side[g] <= r_s_side[g-1];
                r_s_lz[g]   <= r_s_lz[g-1];
                r_s_pexp[g] <= r_s_pexp[g-1];
                r_s_zero[g] <= r_s_zero[g-1];
            end
            for (int g = 0; g < FRAC_W; g++) begin
                r_s_mant[g] <= n_s_mant[g];
                r_s_frac[g] <= n_s_frac[g];
            end

            r_e_side <= r_s_side[FRAC_W-1];
            r_e_cmd  <= n_e_cmd;
        end
    end

    assign o_valid = r_e_valid;
    assign o_side  = r_e_side;
    assign o_cmd   = r_e_cmd;

endmodule

`default_nettype wire

>>> hdl/ppds_exp.sv
// 2^-e by chained root factors, scale change multiply, final sum and clamp.
`default_nettype none

module ppds_exp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  ppds_pkg::t_side              i_side,
    input  ppds_pkg::t_pow_cmd           i_cmd,
    output logic                         o_valid,
    output logic [ppds_pkg::SCALE_W-1:0] o_density_scale,
    output logic [ppds_pkg::SEG_W-1:0]   o_segment_used
);
    import ppds_pkg::*;

    // root factor stages
    logic               r_a_valid [FRAC_W];
    t_side              r_a_side  [FRAC_W];
    t_pow_cmd           r_a_cmd   [FRAC_W];
    logic [MANT_W-1:0]  r_a_acc   [FRAC_W];

    // shift stage
    logic               r_h_valid;
    t_side              r_h_side;
    logic [MANT_W-1:0]  r_h_pow;
    logic [SCALE_W-1:0] r_h_absds;
    logic               r_h_neg;

    // multiply stage
    logic               r_m_valid;
    t_side              r_m_side;
    logic [Q_W-1:0]     r_m_q;
    logic               r_m_neg;

    // output register
    logic               r_o_valid;
    logic [SCALE_W-1:0] r_o_scale;
    logic [SEG_W-1:0]   r_o_seg;

    logic [MANT_W-1:0]  n_a_acc [FRAC_W];
    logic [MANT_W-1:0]  n_h_pow;
    logic [SCALE_W-1:0] n_h_absds;
    logic               n_h_neg;
    logic [Q_W-1:0]     n_m_q;
    logic [SCALE_W-1:0] n_o_scale;

    always_comb begin
        logic [MANT_W+COEF_W-1:0] prod;
        logic [MANT_W-1:0]        acc;
        t_pow_cmd                 cmd;
        for (int g = 0; g < FRAC_W; g++) begin
            if (g == 0) begin
                acc = ONE_Q30;
                cmd = i_cmd;
            end else begin
                acc = r_a_acc[g-1];
                cmd = r_a_cmd[g-1];
            end
            prod = {{COEF_W{1'b0}}, acc} * {{MANT_W{1'b0}}, ROOT_COEF[g]};
            prod = prod + ((MANT_W+COEF_W)'(1) << 29);
            n_a_acc[g] = cmd.frac[FRAC_W-1-g] ? prod[MANT_W+COEF_W-1:30] : acc;
        end
    end

    always_comb begin
        logic [SCALE_W:0] ds;
        t_side            sd;
        t_pow_cmd         cmd;
        sd        = r_a_side[FRAC_W-1];
        cmd       = r_a_cmd[FRAC_W-1];
        n_h_pow   = cmd.kill ? '0 : (r_a_acc[FRAC_W-1] >> cmd.shift);
        ds        = {1'b0, sd.sc1} - {1'b0, sd.sc0};
        n_h_neg   = ds[SCALE_W];
        n_h_absds = n_h_neg ? SCALE_W'(-ds) : ds[SCALE_W-1:0];
    end

    always_comb begin
        logic [SCALE_W+MANT_W:0] mag;
        mag   = {{(MANT_W+1){1'b0}}, r_h_absds} * {{(SCALE_W+1){1'b0}}, r_h_pow};
        mag   = mag + ((SCALE_W+MANT_W+1)'(1) << 29);
        n_m_q = mag[Q_W+29:30];
    end

    always_comb begin
        logic signed [RES_W-1:0] start;
        logic signed [RES_W-1:0] sum;
        logic                    pos;
        pos   = !r_m_side.pex[EXP_W-1];
        start = pos ? RES_W'({1'b0, r_m_side.sc0}) : RES_W'({1'b0, r_m_side.sc1});
        // subtract when growth and exponent sign point opposite ways
        if (pos == r_m_neg) begin
            sum = start - RES_W'({1'b0, r_m_q});
        end else begin
            sum = start + RES_W'({1'b0, r_m_q});
        end
        priority if (r_m_side.bypass) begin
            n_o_scale = r_m_side.sc0;
        end else if (r_m_side.pex == '0) begin
            n_o_scale = ONE_Q12;
        end else if (sum < 0) begin
            n_o_scale = '0;
        end else if (sum > RES_W'({1'b0, SCALE_MAX})) begin
            n_o_scale = SCALE_MAX;
        end else begin
            n_o_scale = sum[SCALE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < FRAC_W; g++) r_a_valid[g] <= 1'b0;
            r_h_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid[0] <= i_valid;
            for (int g = 1; g < FRAC_W; g++) r_a_valid[g] <= r_a_valid[g-1];
            r_h_valid <= r_a_valid[FRAC_W-1];
            r_m_valid <= r_h_valid;
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side[0] <= i_side;
            r_a_cmd[0]  <= i_cmd;
            for (int g = 1; g < FRAC_W; g++) begin
                r_a_side[g] <= r_a_side[g-1];
                r_a_cmd[g]  <= r_a_cmd[g-1];
            end
            for (int g = 0; g < FRAC_W; g++) r_a_acc[g] <= n_a_acc[g];

            r_h_side  <= r_a_side[FRAC_W-1];
            r_h_pow   <= n_h_pow;
            r_h_absds <= n_h_absds;
            r_h_neg   <= n_h_neg;

            r_m_side  <= r_h_side;
            r_m_q     <= n_m_q;
            r_m_neg   <= r_h_neg;

            r_o_scale <= n_o_scale;
            r_o_seg   <= r_m_side.seg;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_density_scale = r_o_scale;
    assign o_segment_used  = r_o_seg;

endmodule

`default_nettype wire

>>> hdl/piecewise_power_density_scale_core.sv
// Pipeline: 42 register stages from accepted request to result, for any radius.
// Throughput: one request per cycle unless a held result stalls; stages carry valid bits.
// Stages: 1 segment search, 4 divider (4 quotient bits each), 1 base select,
//   16 squaring steps of the log, 1 exponent multiply, 16 root factor steps, 3 output.
// Back-pressure: a held result freezes the whole pipe; nothing is lost or repeated.
// Reset (sync, active low): clears valid bits; used count 1, word 0 = scale 1.0, others 0.
`default_nettype none

module piecewise_power_density_scale_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppds_pkg::WORD_W-1:0]    i_cfg_data,
    ppds_req_if.sink                       i_req,
    ppds_rsp_if.source                     o_rsp
);
    import ppds_pkg::*;

    // configuration registers
    logic [USED_W-1:0] r_used;
    t_word             r_word [MAX_BREAKPOINTS];

    // stage interconnect
    logic                en;
    logic                seg_valid;
    t_side               seg_side;
    logic [RADIUS_W-1:0] seg_off;
    logic [RADIUS_W-1:0] seg_width;
    logic                div_valid;
    t_side               div_side;
    logic [RADIUS_W-1:0] div_t;
    logic                log_valid;
    t_side               log_side;
    t_pow_cmd            log_cmd;
    logic                exp_valid;

    // Register writes; indexes past the last word are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= USED_RESET;
            r_word[0] <= WORD0_RESET;
            for (int i = 1; i < MAX_BREAKPOINTS; i++) r_word[i] <= WORD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_USED:  r_used    <= i_cfg_data[USED_W-1:0];
                REG_WORD0: r_word[0] <= i_cfg_data;
                REG_WORD1: r_word[1] <= i_cfg_data;
                REG_WORD2: r_word[2] <= i_cfg_data;
                REG_WORD3: r_word[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Whole pipe advances unless the output register holds an untaken result.
    assign en          = !exp_valid || o_rsp.ready;
    assign i_req.ready = en;

    ppds_seg u_seg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_req.valid),
        .i_radius (i_req.radius),
        .i_used   (r_used),
        .i_words  (r_word),
        .o_valid  (seg_valid),
        .o_side   (seg_side),
        .o_off    (seg_off),
        .o_width  (seg_width)
    );

    // t = offset / width in Q0.16
    ppds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (seg_valid),
        .i_side  (seg_side),
        .i_off   (seg_off),
        .i_width (seg_width),
        .o_valid (div_valid),
        .o_side  (div_side),
        .o_quot  (div_t)
    );

    // e = |p| * -log2(base), split into shift and fraction
    ppds_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_side  (div_side),
        .i_t     (div_t),
        .o_valid (log_valid),
        .o_side  (log_side),
        .o_cmd   (log_cmd)
    );

    // 2^-e, times the scale change, applied to the segment start or end scale
    ppds_exp u_exp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (log_valid),
        .i_side          (log_side),
        .i_cmd           (log_cmd),
        .o_valid         (exp_valid),
        .o_density_scale (o_rsp.density_scale),
        .o_segment_used  (o_rsp.segment_used)
    );

    assign o_rsp.valid = exp_valid;

endmodule

`default_nettype wire

>>> sim/piecewise_power_density_scale_core_tb.sv
// Self-checking testbench of the piecewise power density scale core.
`default_nettype none

module piecewise_power_density_scale_core_tb;
    import ppds_pkg::*;

    // one predicted result: density scale and starting segment
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [SEG_W-1:0]   seg;
    } t_scale_rsp;

    // Scoreboard: owns a copy of the table, predicts each request, checks results.
    class density_scoreboard;
        logic [USED_W-1:0] used_cnt;
        t_word             words [MAX_BREAKPOINTS];
        t_scale_rsp        pending [$];
        int                errors;

        function new();
            used_cnt = USED_RESET;
            words[0] = WORD0_RESET;
            for (int i = 1; i < MAX_BREAKPOINTS; i++) words[i] = WORD_RESET;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_word val);
            if (idx == REG_USED) used_cnt = val[USED_W-1:0];
            else if (idx >= REG_WORD0 && idx <= REG_WORD3) words[idx - REG_WORD0] = val;
        endfunction

        // 2^(-e) style power of a Q1.16 base, Q1.30 result
        function logic [63:0] power_q30(logic [63:0] base, logic [63:0] pexp);
            int          b;
            logic [63:0] m, frac, nl, e, k, f, acc, c, v, res, bit_v;
            b = 16;
            while (b > 0 && base[b] == 1'b0) b--;
            m = base << (30 - b);
            frac = 0;
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd2 << 30)) begin
                    m = m >> 1;
                    frac = frac | 1;
                end
            end
            nl = (64'(16 - b) << 16) - frac;
            e = (nl * pexp + 2048) >> 12;
            k = e >> 16;
            if (k >= 31) return 0;
            f = e & 64'hFFFF;
            acc = 64'd1 << 30;
            c = 64'd1 << 29;
            for (int i = 1; i <= 16; i++) begin
                // floor square root of c << 30
                v = c << 30;
                res = 0;
                bit_v = 64'd1 << 62;
                while (bit_v > v) bit_v = bit_v >> 2;
                while (bit_v != 0) begin
                    if (v >= res + bit_v) begin
                        v = v - (res + bit_v);
                        res = (res >> 1) + bit_v;
                    end else begin
                        res = res >> 1;
                    end
                    bit_v = bit_v >> 2;
                end
                c = res;
                if (f[16 - i]) acc = (acc * c + (64'd1 << 29)) >> 30;
            end
            return acc >> k;
        endfunction

        function t_scale_rsp predict_scale(logic [RADIUS_W-1:0] radius);
            int          n, s;
            longint      kr, result, rad0, rad1, sc0, sc1, ds, pex;
            logic [63:0] off, width, t, powv, mag, q;
            t_scale_rsp  r;
            kr = radius;
            n = used_cnt;
            if (n < 1) n = 1;
            if (n > MAX_BREAKPOINTS) n = MAX_BREAKPOINTS;
            s = 0;
            while (s < n - 1 && kr >= longint'(bp_radius(words[s]))) s++;
            if (s == n - 1 && kr >= longint'(bp_radius(words[s]))) begin
                result = bp_scale(words[s]);
            end else if (s == 0) begin
                result = bp_scale(words[0]);
            end else begin
                s--;
                rad0 = bp_radius(words[s]);
                rad1 = bp_radius(words[s + 1]);
                sc0 = bp_scale(words[s]);
                sc1 = bp_scale(words[s + 1]);
                pex = bp_exp(words[s]);
                if (pex >= 32768) pex -= 65536;
                ds = sc1 - sc0;
                off = kr - rad0;
                width = rad1 - rad0;
                t = (width != 0) ? ((off << 16) / width) : 0;
                if (t > 65535) t = 65535;
                if (pex == 0) begin
                    result = ONE_Q12;
                end else begin
                    if (pex > 0) powv = (t == 0) ? 0 : power_q30(t, pex);
                    else         powv = power_q30(65536 - t, -pex);
                    mag = 64'(ds < 0 ? -ds : ds) * powv;
                    q = (mag + (64'd1 << 29)) >> 30;
                    if (ds < 0) result = (pex > 0) ? sc0 - longint'(q) : sc1 + longint'(q);
                    else        result = (pex > 0) ? sc0 + longint'(q) : sc1 - longint'(q);
                end
            end
            if (result < 0) result = 0;
            if (result > 65535) result = 65535;
            r.scale = result[SCALE_W-1:0];
            r.seg = s[SEG_W-1:0];
            return r;
        endfunction

        function void note_request(logic [RADIUS_W-1:0] radius);
            pending.push_back(predict_scale(radius));
        endfunction

        function void check_result(logic [SCALE_W-1:0] scale, logic [SEG_W-1:0] seg);
            t_scale_rsp want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result scale=%h seg=%0d", $time, scale, seg);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (scale !== want.scale) begin
                $display("%0t: density_scale expected %h actual %h", $time, want.scale, scale);
                errors++;
            end
            if (seg !== want.seg) begin
                $display("%0t: segment_used expected %0d actual %0d", $time, want.seg, seg);
                errors++;
            end
        endfunction
    endclass

    localparam int PIPE_LAT   = 42;
    localparam int WATCH_LIMIT = 20000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    ppds_req_if req_ch();
    ppds_rsp_if rsp_ch();

    density_scoreboard sb = new();

    // idle percentages for the sender and the receiver
    int send_idle = 0;
    int recv_stall = 0;
    int quiet_cycles = 0;

    piecewise_power_density_scale_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.radius = '0;
        rsp_ch.ready = 1'b0;
    end

    // receiver: random stalls, checks every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.density_scale, rsp_ch.segment_used);
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog: cycles with no request or result accepted
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // register write, only while the pipe is empty
    task automatic write_cfg(t_cfg_idx idx, t_word val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // send one request, holding valid until accepted
    task automatic send_radius(logic [RADIUS_W-1:0] radius);
        while ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.radius <= radius;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(radius);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_word make_word(logic [15:0] r, logic [15:0] sc, logic [15:0] ex);
        return {r, sc, ex};
    endfunction

    // mostly ascending table with random scales and exponents, some words fully random
    task automatic load_table(int used);
        logic [15:0] r;
        r = 16'($urandom_range(2000));
        for (int i = 0; i < MAX_BREAKPOINTS; i++) begin
            if ($urandom_range(9) == 0)
                write_cfg(t_cfg_idx'(REG_WORD0 + i), {16'($urandom), 32'($urandom)});
            else
                write_cfg(t_cfg_idx'(REG_WORD0 + i),
                          make_word(r, 16'($urandom), 16'($urandom)));
            r = r + 16'($urandom_range(20000, 1));
            if (r < 16'd100) r = 16'hFFF0;
        end
        write_cfg(REG_USED, t_word'(used));
    endtask

    // radius biased toward breakpoints and their neighbors
    function automatic logic [15:0] pick_radius();
        logic [15:0] b;
        b = bp_radius(sb.words[$urandom_range(MAX_BREAKPOINTS - 1)]);
        case ($urandom_range(3))
            0: return b + 16'($urandom_range(2)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int phase;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset table: single breakpoint, extremes of radius
        send_radius(16'h0000);
        send_radius(16'hFFFF);
        drain();

        // directed table: positive, negative, zero exponents, falling scale,
        // radius below first breakpoint, at the last one, saturation
        write_cfg(REG_WORD0, make_word(16'd1000, 16'h1000, 16'h2000));
        write_cfg(REG_WORD1, make_word(16'd2000, 16'hFFFF, 16'hE000));
        write_cfg(REG_WORD2, make_word(16'd3000, 16'h0000, 16'h0000));
        write_cfg(REG_WORD3, make_word(16'hFFFF, 16'h8000, 16'h8000));
        write_cfg(REG_USED, t_word'(4));
        send_radius(16'd0);     send_radius(16'd999);   send_radius(16'd1000);
        send_radius(16'd1500);  send_radius(16'd1999);  send_radius(16'd2000);
        send_radius(16'd2500);  send_radius(16'd3000);  send_radius(16'd40000);
        send_radius(16'hFFFE);  send_radius(16'hFFFF);
        drain();
        // used count zero and above the table
        write_cfg(REG_USED, t_word'(0));
        send_radius(16'd5);     send_radius(16'hFFFF);
        drain();
        write_cfg(REG_USED, t_word'(7));
        send_radius(16'd1234);  send_radius(16'd2345);
        drain();
        // unordered table, out-of-range register index ignored
        write_cfg(REG_WORD1, make_word(16'd500, 16'h0100, 16'h7FFF));
        write_cfg(t_cfg_idx'(5), 48'hFFFF_FFFF_FFFF);
        write_cfg(t_cfg_idx'(7), 48'h0);
        send_radius(16'd600);   send_radius(16'd1200);  send_radius(16'd2999);
        drain();

        // random phases with varying idle patterns and tables
        for (phase = 0; phase < 24; phase++) begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 59; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 59; end
                default: begin send_idle = 7; recv_stall = 7; end
            endcase
            load_table($urandom_range(7));
            for (int i = 0; i < 80; i++) begin
                send_radius(pick_radius());
                // pause until all results have come back
                if (i == 40 && phase % 6 == 0) drain();
            end
            drain();
        end

        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire

>>> files.f
hdl/ppds_pkg.sv
hdl/ppds_if.sv
hdl/ppds_seg.sv
hdl/ppds_div.sv
hdl/ppds_log.sv
hdl/ppds_exp.sv
hdl/piecewise_power_density_scale_core.sv
sim/piecewise_power_density_scale_core_tb.sv
